### sv/scjf_pkg.sv
// ---------------------------------------------------------------------------
// scjf_pkg
// Shared types, codes and the command byte generator for the serial camera
// JPEG fetch controller.
// ---------------------------------------------------------------------------
package scjf_pkg;

	// Event kinds on the input stream (tuser)
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_RXBYTE = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	// Result kinds on the output stream (tuser)
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_CMD = 2'd1;
	localparam logic [1:0] KIND_IMG = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_RESET_WAIT = 2'd0;
	localparam logic [1:0] REG_READ_WAIT = 2'd1;
	localparam logic [1:0] REG_CHUNK_LEN = 2'd2;

	// Configuration reset values
	localparam logic [15:0] RESET_WAIT_RST = 16'd4000;
	localparam logic [7:0] READ_WAIT_RST = 8'd25;
	localparam logic [7:0] CHUNK_LEN_RST = 8'd32;

	// Protocol bytes
	localparam logic [7:0] CAM_SYNC = 8'h56;
	localparam logic [7:0] CAM_RESET = 8'h26;
	localparam logic [7:0] CAM_SNAP = 8'h36;
	localparam logic [7:0] CAM_READ = 8'h32;
	localparam logic [7:0] CAM_JPEG = 8'h0c;
	localparam logic [7:0] CAM_DELAY = 8'h0a;
	localparam logic [7:0] JPEG_EOI0 = 8'hFF;
	localparam logic [7:0] JPEG_EOI1 = 8'hD9;
	localparam logic [7:0] HDR_BYTES = 8'd5;

	// Burst lengths in result items
	localparam int RST_LEN = 4;
	localparam int SNAP_LEN = 5;
	localparam int READ_LEN = 16;
	localparam int MAX_BURST = SNAP_LEN + READ_LEN;
	localparam int IDX_W = $clog2(MAX_BURST);

	// Default depth of the burst queue
	localparam int QUEUE_DEPTH_DEF = 4;

	// Controller phase, one-hot
	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_RWAIT = 4'b0010,
		PH_READ  = 4'b0100,
		PH_DONE  = 4'b1000
	} phase_t;

	// What one accepted event expands to on the output
	typedef enum logic [2:0] {
		BR_NONE,
		BR_RESET,
		BR_SNAPREAD,
		BR_READ,
		BR_IMG,
		BR_IMGDONE
	} burst_kind_t;

	typedef struct packed {
		burst_kind_t bk;
		logic [15:0] addr;
		logic [7:0]  len;
		logic [7:0]  img;
	} burst_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       last;
	} res_t;

	// Byte j of the read-data command
	function automatic logic [7:0] read_cmd_byte(input logic [IDX_W-1:0] j,
			input logic [15:0] addr, input logic [7:0] len);
		logic [7:0] b;
		case (j)
			IDX_W'(0):  b = CAM_SYNC;
			IDX_W'(2):  b = CAM_READ;
			IDX_W'(3):  b = CAM_JPEG;
			IDX_W'(5):  b = CAM_DELAY;
			IDX_W'(8):  b = addr[15:8];
			IDX_W'(9):  b = addr[7:0];
			IDX_W'(13): b = len;
			IDX_W'(15): b = CAM_DELAY;
			default:    b = 8'h00;
		endcase
		return b;
	endfunction

	// Result item number idx of a burst
	function automatic res_t burst_item(input burst_t d, input logic [IDX_W-1:0] idx);
		res_t r;
		r = '{kind: KIND_NONE, value: 8'h00, last: 1'b1};
		case (d.bk)
			BR_RESET: begin
				r.kind = KIND_CMD;
				r.last = (idx == IDX_W'(RST_LEN - 1));
				case (idx)
					IDX_W'(0): r.value = CAM_SYNC;
					IDX_W'(2): r.value = CAM_RESET;
					default:   r.value = 8'h00;
				endcase
			end
			BR_SNAPREAD: begin
				r.kind = KIND_CMD;
				r.last = (idx == IDX_W'(MAX_BURST - 1));
				case (idx)
					IDX_W'(0): r.value = CAM_SYNC;
					IDX_W'(1): r.value = 8'h00;
					IDX_W'(2): r.value = CAM_SNAP;
					IDX_W'(3): r.value = 8'h01;
					IDX_W'(4): r.value = 8'h00;
					default:   r.value = read_cmd_byte(idx - IDX_W'(SNAP_LEN), d.addr, d.len);
				endcase
			end
			BR_READ: begin
				r.kind = KIND_CMD;
				r.last = (idx == IDX_W'(READ_LEN - 1));
				r.value = read_cmd_byte(idx, d.addr, d.len);
			end
			BR_IMG: begin
				r.kind = KIND_IMG;
				r.value = d.img;
			end
			BR_IMGDONE: begin
				if (idx == IDX_W'(0)) begin
					r.kind = KIND_IMG;
					r.value = d.img;
					r.last = 1'b0;
				end else begin
					r.kind = KIND_DONE;
				end
			end
			default: r = '{kind: KIND_NONE, value: 8'h00, last: 1'b1};
		endcase
		return r;
	endfunction

endpackage

### sv/serial_camera_jpeg_fetch.sv
// ---------------------------------------------------------------------------
// serial_camera_jpeg_fetch
// Command and readout controller for a serial JPEG camera: reset, snapshot,
// chunked read-data commands and image byte capture up to the FF D9 marker.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one event per item; s_tuser is the event kind
//   (start, received byte, millisecond tick), s_tdata the received byte.
//   Output stream (m_*): result items; m_tuser is the kind (nothing, command
//   byte, image byte, image complete), m_tdata the byte, m_tlast marks the
//   final result of one event. Every event gives at least one result.
//   Config port (cfg_*): always ready; write only while the block is idle.
// Timing:
//   Each event is decoded and the controller state updated in the cycle it
//   is accepted; the event's result burst (1 to 21 items) goes into a queue
//   of QUEUE_DEPTH bursts. Results leave the queue through the output
//   register, one item per cycle while m_tready is high. An event is
//   accepted every cycle while the burst queue has room, so input
//   throughput is one event per cycle when bursts are single items and is
//   bounded by the output drain rate for command bursts.
// Reset: the phase goes idle, counters and address clear, the queue empties
//   and the configuration registers take their default values.
// Stall: a stalled output holds its item; the queue fills and s_tready drops.
// ---------------------------------------------------------------------------
module serial_camera_jpeg_fetch
	import scjf_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input events
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] op
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] value
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// configuration
	logic [15:0] reset_wait_q;
	logic [7:0]  read_wait_q;
	logic [7:0]  chunk_len_q;

	// controller state
	phase_t      phase_q, phase_d;
	logic [15:0] wait_cnt_q, wait_cnt_d;
	logic [15:0] addr_q, addr_d;
	logic [7:0]  reply_cnt_q, reply_cnt_d;
	logic [7:0]  capt_cnt_q, capt_cnt_d;
	logic        end_seen_q, end_seen_d;
	logic [7:0]  prev_byte_q, prev_byte_d;
	burst_t      burst_d;

	// burst queue
	burst_t            queue_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;

	// output register
	logic        out_valid_q;
	res_t        out_q;

	logic        in_acc, load, pop;
	res_t        item;
	logic [15:0] wait_inc;
	logic [7:0]  reply_inc;

	assign cfg_ready = 1'b1;
	assign s_tready  = (count_q != CNT_W'(QUEUE_DEPTH));
	assign in_acc    = s_tvalid && s_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_wait_q <= RESET_WAIT_RST;
			read_wait_q  <= READ_WAIT_RST;
			chunk_len_q  <= CHUNK_LEN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RESET_WAIT: reset_wait_q <= cfg_data;
				REG_READ_WAIT:  read_wait_q  <= cfg_data[7:0];
				REG_CHUNK_LEN:  chunk_len_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign wait_inc  = (wait_cnt_q == 16'hFFFF) ? wait_cnt_q : wait_cnt_q + 16'd1;
	assign reply_inc = (reply_cnt_q == 8'hFF) ? reply_cnt_q : reply_cnt_q + 8'd1;

	// event decode and next state
	always_comb begin
		phase_d     = phase_q;
		wait_cnt_d  = wait_cnt_q;
		addr_d      = addr_q;
		reply_cnt_d = reply_cnt_q;
		capt_cnt_d  = capt_cnt_q;
		end_seen_d  = end_seen_q;
		prev_byte_d = prev_byte_q;
		burst_d     = '{bk: BR_NONE, addr: addr_q, len: chunk_len_q, img: s_tdata};
		case (s_tuser)
			OP_START: begin
				if (phase_q == PH_IDLE || phase_q == PH_DONE) begin
					addr_d      = '0;
					end_seen_d  = 1'b0;
					prev_byte_d = '0;
					reply_cnt_d = '0;
					capt_cnt_d  = '0;
					wait_cnt_d  = '0;
					phase_d     = PH_RWAIT;
					burst_d.bk  = BR_RESET;
				end
			end
			OP_RXBYTE: begin
				if (phase_q == PH_READ) begin
					reply_cnt_d = reply_inc;
					if (reply_inc > HDR_BYTES && capt_cnt_q < chunk_len_q && !end_seen_q) begin
						prev_byte_d = s_tdata;
						capt_cnt_d  = capt_cnt_q + 8'd1;
						if (prev_byte_q == JPEG_EOI0 && s_tdata == JPEG_EOI1) begin
							end_seen_d = 1'b1;
							phase_d    = PH_DONE;
							burst_d.bk = BR_IMGDONE;
						end else begin
							burst_d.bk = BR_IMG;
						end
					end
				end
			end
			OP_TICK: begin
				if (phase_q == PH_RWAIT || phase_q == PH_READ) begin
					wait_cnt_d = wait_inc;
					if ((phase_q == PH_RWAIT && wait_inc >= reset_wait_q) ||
					    (phase_q == PH_READ && wait_inc >= {8'h00, read_wait_q})) begin
						burst_d.bk  = (phase_q == PH_RWAIT) ? BR_SNAPREAD : BR_READ;
						addr_d      = addr_q + {8'h00, chunk_len_q};
						reply_cnt_d = '0;
						capt_cnt_d  = '0;
						wait_cnt_d  = '0;
						phase_d     = PH_READ;
					end
				end
			end
			default: ;
		endcase
	end

	// controller state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			wait_cnt_q  <= '0;
			addr_q      <= '0;
			reply_cnt_q <= '0;
			capt_cnt_q  <= '0;
			end_seen_q  <= 1'b0;
			prev_byte_q <= '0;
		end else if (in_acc) begin
			phase_q     <= phase_d;
			wait_cnt_q  <= wait_cnt_d;
			addr_q      <= addr_d;
			reply_cnt_q <= reply_cnt_d;
			capt_cnt_q  <= capt_cnt_d;
			end_seen_q  <= end_seen_d;
			prev_byte_q <= prev_byte_d;
		end
	end

	// burst queue storage
	always_ff @(posedge clk) begin
		if (in_acc) begin
			queue_mem[wr_ptr_q] <= burst_d;
		end
	end

	// serializer: one result item per load from the head burst
	assign item = burst_item(queue_mem[rd_ptr_q], idx_q);
	assign load = (count_q != '0) && (!out_valid_q || m_tready);
	assign pop  = load && item.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (in_acc && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!in_acc && pop) begin
				count_q <= count_q - 1'b1;
			end
			if (load) begin
				idx_q <= item.last ? '0 : idx_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= item;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.value;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;

endmodule

### sv/scjf_checker.sv
// ---------------------------------------------------------------------------
// scjf_checker
// Port-level checks for the serial camera JPEG fetch controller.
// ---------------------------------------------------------------------------
module scjf_checker
	import scjf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// empty and complete items carry no byte
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_NONE || m_tuser == KIND_DONE) |-> m_tdata == 8'h00)
		else $error("nonzero value on empty or complete item");

	// complete closes its event's burst
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_DONE |-> m_tlast)
		else $error("image complete not last");

	// an empty result is the whole burst
	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_NONE |-> m_tlast)
		else $error("empty result not last");

endmodule

bind serial_camera_jpeg_fetch scjf_checker u_scjf_checker (.*);

### test/serial_camera_jpeg_fetch_tb.sv
// ---------------------------------------------------------------------------
// serial_camera_jpeg_fetch_tb
// Self-checking bench for the serial camera JPEG fetch controller. Events are
// queued with a cycle-free model of the controller that predicts every result
// item, a driver feeds the event stream, and a monitor checks each result item
// in order. Runs an opening capture, directed protocol cases and state-aware
// random captures under three input/output idling mixes, and finally runs
// the last capture through to its end marker.
// ---------------------------------------------------------------------------
module serial_camera_jpeg_fetch_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import scjf_pkg::*;

	localparam int CLK_PERIOD = 8;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_REPORTS = 40;

	// Event code that the controller has no use for
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] rx;
	} cam_event_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       last;
	} cam_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
	logic [1:0]  s_tuser = 2'd0;    // [1:0] op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;           // [7:0] value
	logic [1:0]  m_tuser;           // [1:0] kind
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [15:0] cfg_data = 16'h0000;

	serial_camera_jpeg_fetch u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Events waiting for the driver, result items waiting for the monitor
	cam_event_t  event_q[$];
	cam_result_t exp_q[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int err_count = 0;
	int cycle_cnt = 0;

	// Run statistics
	int events_sent = 0;
	int results_seen = 0;
	int img_bytes = 0;
	int images_done = 0;
	int read_cmds = 0;
	int addr_wraps = 0;

	// Controller copy: configuration and state
	logic [15:0] rst_wait_cfg = RESET_WAIT_RST;
	logic [7:0]  read_wait_cfg = READ_WAIT_RST;
	logic [7:0]  chunk_cfg = CHUNK_LEN_RST;
	phase_t      cam_phase = PH_IDLE;
	logic [15:0] wait_cnt = '0;
	logic [15:0] rd_addr = '0;
	logic [7:0]  reply_cnt = '0;
	logic [7:0]  capt_cnt = '0;
	logic        eoi_seen = 1'b0;
	logic [7:0]  last_img = '0;

	// The newest result of an event is held back so its last flag can be set
	cam_result_t held;
	bit          have_held = 1'b0;

	cam_event_t  next_event;
	cam_result_t want_result;

	// Directed byte sequences: reply headers and the first image chunk
	logic [7:0] queue_event_hdr1 [5] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
	logic [7:0] queue_event_img1 [4] = '{8'hFF, 8'h00, 8'h7F, 8'hFF};
	// marker bytes inside the header must not count; ends on a plain byte
	logic [7:0] queue_event_hdr2 [5] = '{8'hFF, 8'hD9, 8'hFF, 8'hD9, 8'h00};

	task report_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task stage_result(input logic [1:0] kind, input logic [7:0] value);
		if (have_held)
			exp_q.push_back(held);
		held = '{kind: kind, value: value, last: 1'b0};
		have_held = 1'b1;
	endtask

	// Read-data command at the current address; opens a new receive window
	task automatic issue_read();
		logic [7:0]  cmd [16];
		logic [15:0] next_addr;
		cmd = '{CAM_SYNC, 8'h00, CAM_READ, CAM_JPEG, 8'h00, CAM_DELAY, 8'h00, 8'h00,
			rd_addr[15:8], rd_addr[7:0], 8'h00, 8'h00, 8'h00, chunk_cfg, 8'h00, CAM_DELAY};
		for (int j = 0; j < 16; j++)
			stage_result(KIND_CMD, cmd[j]);
		next_addr = rd_addr + {8'h00, chunk_cfg};
		if (next_addr < rd_addr)
			addr_wraps++;
		rd_addr = next_addr;
		reply_cnt = '0;
		capt_cnt = '0;
		wait_cnt = '0;
		cam_phase = PH_READ;
		read_cmds++;
	endtask

	// Expected result items of one event, appended to exp_q
	task automatic camera_predict(input logic [1:0] op, input logic [7:0] rx);
		case (op)
			OP_START: begin
				// start is ignored while a capture is under way
				if (cam_phase == PH_IDLE || cam_phase == PH_DONE) begin
					rd_addr = '0;
					eoi_seen = 1'b0;
					last_img = '0;
					reply_cnt = '0;
					capt_cnt = '0;
					wait_cnt = '0;
					stage_result(KIND_CMD, CAM_SYNC);
					stage_result(KIND_CMD, 8'h00);
					stage_result(KIND_CMD, CAM_RESET);
					stage_result(KIND_CMD, 8'h00);
					cam_phase = PH_RWAIT;
				end
			end
			OP_RXBYTE: begin
				if (cam_phase == PH_READ) begin
					if (reply_cnt != 8'hFF)
						reply_cnt++;
					if (reply_cnt > HDR_BYTES && capt_cnt < chunk_cfg && !eoi_seen) begin
						stage_result(KIND_IMG, rx);
						img_bytes++;
						// marker test uses the last captured byte, even from the previous chunk
						if (last_img == JPEG_EOI0 && rx == JPEG_EOI1)
							eoi_seen = 1'b1;
						last_img = rx;
						capt_cnt++;
						if (eoi_seen) begin
							stage_result(KIND_DONE, 8'h00);
							cam_phase = PH_DONE;
							images_done++;
						end
					end
				end
			end
			OP_TICK: begin
				if (cam_phase == PH_RWAIT) begin
					if (wait_cnt != 16'hFFFF)
						wait_cnt++;
					if (wait_cnt >= rst_wait_cfg) begin
						stage_result(KIND_CMD, CAM_SYNC);
						stage_result(KIND_CMD, 8'h00);
						stage_result(KIND_CMD, CAM_SNAP);
						stage_result(KIND_CMD, 8'h01);
						stage_result(KIND_CMD, 8'h00);
						issue_read();
					end
				end else if (cam_phase == PH_READ) begin
					if (wait_cnt != 16'hFFFF)
						wait_cnt++;
					if (wait_cnt >= {8'h00, read_wait_cfg})
						issue_read();
				end
			end
			default: ;
		endcase
		if (!have_held)
			held = '{kind: KIND_NONE, value: 8'h00, last: 1'b0};
		held.last = 1'b1;
		exp_q.push_back(held);
		have_held = 1'b0;
	endtask

	task queue_event(input logic [1:0] op, input logic [7:0] rx);
		camera_predict(op, rx);
		event_q.push_back('{op: op, rx: rx});
	endtask

	task wait_drained();
		do @(negedge clk); while (exp_q.size() != 0);
	endtask

	task write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_RESET_WAIT: rst_wait_cfg = data;
			REG_READ_WAIT:  read_wait_cfg = data[7:0];
			REG_CHUNK_LEN:  chunk_cfg = data[7:0];
			default: ;
		endcase
	endtask

	// Reconfigure only once the controller has nothing in flight
	task set_config(input logic [15:0] rst_wait, input logic [7:0] read_wait,
			input logic [7:0] chunk);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_RESET_WAIT, rst_wait);
		write_reg(REG_READ_WAIT, {8'h00, read_wait});
		write_reg(REG_CHUNK_LEN, {8'h00, chunk});
		@(negedge clk);
	endtask

	// Random events that mostly follow the protocol from the current state
	task automatic gen_events(input int count);
		int made;
		int r;
		logic [7:0] b;
		made = 0;
		while (made < count) begin
			r = $urandom_range(99);
			if (r < 8) begin
				// noise: any code, any byte
				queue_event(2'($urandom_range(3)), 8'($urandom));
			end else begin
				made++;
				case (cam_phase)
					PH_IDLE, PH_DONE: queue_event(r < 90 ? OP_START : OP_RXBYTE, 8'($urandom));
					PH_RWAIT: queue_event(OP_TICK, 8'($urandom));
					default: begin
						if (reply_cnt < HDR_BYTES) begin
							queue_event(OP_RXBYTE, 8'($urandom));
						end else if (capt_cnt < chunk_cfg && !eoi_seen && r < 90) begin
							if (last_img == JPEG_EOI0 && $urandom_range(1) == 1)
								b = JPEG_EOI1;
							else if ($urandom_range(9) == 0)
								b = JPEG_EOI0;
							else
								b = 8'($urandom);
							queue_event(OP_RXBYTE, b);
						end else begin
							queue_event(OP_TICK, 8'($urandom));
						end
					end
				endcase
			end
		end
	endtask

	// Push the current capture through to the end marker
	task automatic run_to_done();
		while (cam_phase != PH_DONE && cam_phase != PH_IDLE) begin
			if (cam_phase == PH_RWAIT || (reply_cnt >= HDR_BYTES && capt_cnt >= chunk_cfg))
				queue_event(OP_TICK, 8'($urandom));
			else if (reply_cnt < HDR_BYTES)
				queue_event(OP_RXBYTE, 8'($urandom));
			else
				queue_event(OP_RXBYTE, last_img == JPEG_EOI0 ? JPEG_EOI1 : JPEG_EOI0);
		end
	endtask

	// Event driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tuser <= 2'd0;
		end else begin
			if (s_tvalid && s_tready) begin
				void'(event_q.pop_front());
				events_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (event_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					next_event = event_q[0];
					s_tvalid <= 1'b1;
					s_tdata <= next_event.rx;
					s_tuser <= next_event.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (exp_q.size() == 0) begin
					report_mismatch($sformatf("unexpected item kind %0d value %02h last %0d",
						m_tuser, m_tdata, m_tlast));
				end else begin
					want_result = exp_q.pop_front();
					if (m_tuser !== want_result.kind)
						report_mismatch($sformatf("item %0d kind %0d, expected %0d",
							results_seen, m_tuser, want_result.kind));
					if (m_tdata !== want_result.value)
						report_mismatch($sformatf("item %0d value %02h, expected %02h",
							results_seen, m_tdata, want_result.value));
					if (m_tlast !== want_result.last)
						report_mismatch($sformatf("item %0d last %0d, expected %0d",
							results_seen, m_tlast, want_result.last));
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("serial_camera_jpeg_fetch_tb failed");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sender idles often, receiver more often
		send_idle_pct = 36;
		recv_idle_pct = 60;

		// short reset wait; read window and chunk keep their defaults
		write_reg(REG_RESET_WAIT, 16'd3);
		@(negedge clk);

		// events before any start, then one capture
		queue_event(OP_TICK, 8'h00);
		queue_event(OP_RXBYTE, 8'hFF);
		queue_event(OP_UNUSED, 8'hFF);
		queue_event(OP_START, 8'h00);
		while (cam_phase == PH_RWAIT)
			queue_event(OP_TICK, 8'($urandom));
		gen_events(20);
		run_to_done();

		// directed protocol walk: chunk limit, marker split over two chunks
		set_config(16'd2, 8'd3, 8'd4);
		queue_event(OP_TICK, 8'h55);
		queue_event(OP_RXBYTE, 8'hAA);
		queue_event(OP_UNUSED, 8'h00);
		queue_event(OP_START, 8'hFF);
		queue_event(OP_START, 8'h00);
		queue_event(OP_RXBYTE, 8'hFF);
		queue_event(OP_TICK, 8'h00);
		queue_event(OP_TICK, 8'hFF);
		foreach (queue_event_hdr1[i])
			queue_event(OP_RXBYTE, queue_event_hdr1[i]);
		foreach (queue_event_img1[i])
			queue_event(OP_RXBYTE, queue_event_img1[i]);
		queue_event(OP_RXBYTE, JPEG_EOI1);
		repeat (3) queue_event(OP_TICK, 8'h00);
		foreach (queue_event_hdr2[i])
			queue_event(OP_RXBYTE, queue_event_hdr2[i]);
		queue_event(OP_RXBYTE, JPEG_EOI1);
		queue_event(OP_RXBYTE, 8'h12);
		queue_event(OP_TICK, 8'h00);
		queue_event(OP_START, 8'h00);

		// zero waits and zero chunk: nothing captured, address holds
		set_config(16'd0, 8'd0, 8'd0);
		queue_event(OP_TICK, 8'h00);
		repeat (7) queue_event(OP_RXBYTE, 8'($urandom));
		queue_event(OP_TICK, 8'h00);
		repeat (2) queue_event(OP_RXBYTE, 8'($urandom));
		queue_event(OP_TICK, 8'h00);

		set_config(16'd3, 8'd2, 8'd6);
		gen_events(50);

		// receiver idles often, sender more often; sender pauses midway
		set_config(16'd1, 8'd255, 8'd255);
		send_idle_pct = 60;
		recv_idle_pct = 36;
		gen_events(30);
		wait_drained();
		gen_events(30);

		// no idling from here on
		set_config(16'd5, 8'd4, 8'd1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		gen_events(60);
		run_to_done();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (exp_q.size() != 0)
			report_mismatch($sformatf("%0d result items never arrived", exp_q.size()));

		$display("run: %0d events, %0d result items, %0d image bytes, %0d images completed",
			events_sent, results_seen, img_bytes, images_done);
		$display("run: %0d read commands, %0d address wraps, %0d mismatches",
			read_cmds, addr_wraps, err_count);
		if (err_count == 0)
			$display("serial_camera_jpeg_fetch_tb passed");
		else
			$display("serial_camera_jpeg_fetch_tb failed");
		$finish;
	end

endmodule
